// ===== rtl/core/lrbd_pkg.sv =====
package lrbd_pkg;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int YAW_W   = 16;

   // Datapath widths. Differences of two coordinates need one extra bit.
   localparam int OPD_W   = COORD_W + 1;
   localparam int PROD_W  = 2 * OPD_W;
   // Determinant and s numerator: two 16 x 33 products summed.
   localparam int DET_W   = YAW_W + OPD_W + 1;
   localparam int DEN_W   = DET_W - 1;
   // t numerator: difference of two 33 x 33 products.
   localparam int TNUM_W  = PROD_W + 1;

   // The t numerator is scaled by the sine/cosine fraction before division.
   localparam int FRAC_SHIFT = 14;

   // The divider produces QUOT_W quotient bits. Anything wider saturates.
   localparam int QUOT_W    = COORD_W + 1;
   localparam int NLO_W     = QUOT_W;
   localparam int NHI_W     = TNUM_W - 1 + FRAC_SHIFT - NLO_W;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int MUL_STEP_W = 3;
   localparam logic [MUL_STEP_W-1:0] MUL_LAST_STEP = 3'd6;

   typedef enum logic [1:0] {
      CSR_REF_X   = 2'd0,
      CSR_REF_Y   = 2'd1,
      CSR_YAW_SIN = 2'd2,
      CSR_YAW_COS = 2'd3
   } lrbd_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_TEST,
      ST_DSTART,
      ST_DWAIT,
      ST_UPDATE,
      ST_EMIT
   } lrbd_state_type;

   typedef struct packed {
      logic              sat;
      logic [QUOT_W-1:0] quot;
   } lrbd_div_result_type;

endpackage

// ===== rtl/core/lrbd_divider.sv =====
module lrbd_divider
   import lrbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NHI_W-1:0]    num_hi,
   input  logic [NLO_W-1:0]    num_lo,
   input  logic [DEN_W-1:0]    den,
   output logic                done,
   output lrbd_div_result_type result
);

   // Restoring divider, one quotient bit per cycle. The upper part of the
   // numerator must be below the divisor, otherwise the quotient overflows.

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DET_W-1:0]     rem_ff, rem_in;
   logic [NLO_W-1:0]     lo_ff, lo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic                 sat_ff, sat_in;
   logic [DET_W-1:0]     shifted;
   logic                 fits;

   assign shifted = {rem_ff[DET_W-2:0], lo_ff[NLO_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      if (start) begin
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = DET_W'(num_hi);
         lo_in   = num_lo;
         den_in  = den;
         quot_in = '0;
         sat_in  = DEN_W'(num_hi) >= den;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
         rem_in  = fits ? (shifted - DET_W'(den_ff)) : shifted;
         lo_in   = {lo_ff[NLO_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign done        = done_ff;
   assign result.sat  = sat_ff;
   assign result.quot = quot_ff;

endmodule

// ===== rtl/core/lateral_ray_boundary_distance_top.sv =====
// Sequence: a first vertex is only accepted; a segment that misses is accepted, runs 7 multiply
// steps and is tested; a segment that hits then starts the 33-step restoring divider, waits
// for its registered done flag and updates the kept distance. One request is handled at a
// time, and the divider sets the pace. A last vertex loads the result register in the emit
// state, held there while an earlier result waits. Reset (synchronous, active high) clears
// control, configuration, polyline and result-valid state; yaw_cos resets to 1.0, the rest to 0.
module lateral_ray_boundary_distance_top
   import lrbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [COORD_W-1:0] rsp_lateral_distance,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   // Configuration registers. Writes are always taken; software must write them
   // only while the block is idle. The block itself does not enforce this.
   logic [COORD_W-1:0] ref_x_ff, ref_y_ff;
   logic [YAW_W-1:0]   yaw_sin_ff, yaw_cos_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff   <= '0;
         ref_y_ff   <= '0;
         yaw_sin_ff <= '0;
         yaw_cos_ff <= YAW_W'(16384);
      end else if (csr_valid && csr_ready) begin
         case (lrbd_csr_type'(csr_index))
            CSR_REF_X:   ref_x_ff   <= csr_wdata;
            CSR_REF_Y:   ref_y_ff   <= csr_wdata;
            CSR_YAW_SIN: yaw_sin_ff <= csr_wdata[YAW_W-1:0];
            CSR_YAW_COS: yaw_cos_ff <= csr_wdata[YAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and its control outputs.
   lrbd_state_type state_ff, state_in;
   logic [MUL_STEP_W-1:0] mul_step_ff, mul_step_in;

   logic take_req, mul_en, test_en, div_start, upd_en, emit_load;
   logic hit;
   logic div_done;
   lrbd_div_result_type div_result;

   // Polyline state.
   logic [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic               have_prev_ff;
   logic [COORD_W-1:0] best_distance_ff;
   logic               best_valid_ff;
   logic               last_ff;

   // Segment operands, captured when a request is taken.
   logic [OPD_W-1:0] dx_ff, dy_ff, rx_ff, ry_ff;

   // Shared multiplier and its accumulators.
   logic signed [OPD_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0]        prod_ff;
   logic [DET_W-1:0]         det_ff, det_in;
   logic [DET_W-1:0]         snum_ff, snum_in;
   logic [TNUM_W-1:0]        tnum_ff, tnum_in;

   // Divider operands.
   logic [DEN_W-1:0] den_ff;
   logic [NHI_W-1:0] numhi_ff;
   logic [NLO_W-1:0] numlo_ff;
   logic             neg_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [COORD_W-1:0] rsp_distance_ff;

   // ---------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (have_prev_ff) begin
                  state_in = ST_MUL;
               end else if (req_last_point) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            if (mul_step_ff == MUL_LAST_STEP) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (hit) begin
               state_in = ST_DSTART;
            end else begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs.
   // ---------------------------------------------------------------------
   always_comb begin
      take_req  = 1'b0;
      mul_en    = 1'b0;
      test_en   = 1'b0;
      div_start = 1'b0;
      upd_en    = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         ST_IDLE:   take_req  = 1'b1;
         ST_MUL:    mul_en    = 1'b1;
         ST_TEST:   test_en   = 1'b1;
         ST_DSTART: div_start = 1'b1;
         ST_DWAIT: begin
         end
         ST_UPDATE: upd_en    = 1'b1;
         ST_EMIT:   emit_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign req_ready = take_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mul_step_ff <= '0;
      end else begin
         state_ff    <= state_in;
         mul_step_ff <= mul_step_in;
      end
   end

   assign mul_step_in = mul_en ? (mul_step_ff + 1'b1) : '0;

   // ---------------------------------------------------------------------
   // Request capture. The segment runs from the previous vertex to this one,
   // and the reference offset is taken at its start.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && take_req) begin
         dx_ff   <= {req_point_x[COORD_W-1], req_point_x} - {prev_x_ff[COORD_W-1], prev_x_ff};
         dy_ff   <= {req_point_y[COORD_W-1], req_point_y} - {prev_y_ff[COORD_W-1], prev_y_ff};
         rx_ff   <= {prev_x_ff[COORD_W-1], prev_x_ff} - {ref_x_ff[COORD_W-1], ref_x_ff};
         ry_ff   <= {prev_y_ff[COORD_W-1], prev_y_ff} - {ref_y_ff[COORD_W-1], ref_y_ff};
         last_ff <= req_last_point;
      end
   end

   // ---------------------------------------------------------------------
   // Multiply sequence. Each step forms one product; the step after adds it
   // in. Steps 0-2 build the determinant sin*dy + cos*dx, steps 2-4 the s
   // numerator -(sin*ry) - cos*rx, and steps 4-6 the t numerator
   // dx*ry - dy*rx.
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = $signed(dx_ff);
      mul_b = $signed(ry_ff);
      case (mul_step_ff)
         3'd0: begin
            mul_a = $signed({{(OPD_W-YAW_W){yaw_sin_ff[YAW_W-1]}}, yaw_sin_ff});
            mul_b = $signed(dy_ff);
         end
         3'd1: begin
            mul_a = $signed({{(OPD_W-YAW_W){yaw_cos_ff[YAW_W-1]}}, yaw_cos_ff});
            mul_b = $signed(dx_ff);
         end
         3'd2: begin
            mul_a = $signed({{(OPD_W-YAW_W){yaw_sin_ff[YAW_W-1]}}, yaw_sin_ff});
            mul_b = $signed(ry_ff);
         end
         3'd3: begin
            mul_a = $signed({{(OPD_W-YAW_W){yaw_cos_ff[YAW_W-1]}}, yaw_cos_ff});
            mul_b = $signed(rx_ff);
         end
         3'd4: begin
            mul_a = $signed(dx_ff);
            mul_b = $signed(ry_ff);
         end
         3'd5: begin
            mul_a = $signed(dy_ff);
            mul_b = $signed(rx_ff);
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      det_in  = det_ff;
      snum_in = snum_ff;
      tnum_in = tnum_ff;
      if (mul_en) begin
         case (mul_step_ff)
            3'd1: det_in  = prod_ff[DET_W-1:0];
            3'd2: det_in  = det_ff + prod_ff[DET_W-1:0];
            3'd3: snum_in = '0 - prod_ff[DET_W-1:0];
            3'd4: snum_in = snum_ff - prod_ff[DET_W-1:0];
            3'd5: tnum_in = {prod_ff[PROD_W-1], prod_ff};
            3'd6: tnum_in = tnum_ff - {prod_ff[PROD_W-1], prod_ff};
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      det_ff  <= det_in;
      snum_ff <= snum_in;
      tnum_ff <= tnum_in;
   end

   // ---------------------------------------------------------------------
   // Hit test. A parallel segment (zero determinant) is skipped, as is a hit
   // whose segment parameter snum/det lies outside [0, 1]; the parameter test
   // compares the numerator against zero and the determinant exactly.
   // ---------------------------------------------------------------------
   logic              det_neg, range_ok;
   logic [DET_W-1:0]  det_abs;
   logic [TNUM_W-1:0] tnum_abs;

   assign det_neg  = det_ff[DET_W-1];
   assign range_ok = det_neg ?
                     ($signed(snum_ff) <= 0 && $signed(snum_ff) >= $signed(det_ff)) :
                     ($signed(snum_ff) >= 0 && $signed(snum_ff) <= $signed(det_ff));
   assign hit      = (det_ff != '0) && range_ok;
   assign det_abs  = det_neg ? ('0 - det_ff) : det_ff;
   assign tnum_abs = tnum_ff[TNUM_W-1] ? ('0 - tnum_ff) : tnum_ff;

   // The scaled numerator |tnum| * 2^14 is split so that its upper part is
   // compared once against the divisor and its lower part feeds the
   // quotient bits.
   always_ff @(posedge clock) begin
      if (test_en) begin
         den_ff   <= det_abs[DEN_W-1:0];
         numhi_ff <= tnum_abs[TNUM_W-2:NLO_W-FRAC_SHIFT];
         numlo_ff <= {tnum_abs[NLO_W-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
         neg_ff   <= tnum_ff[TNUM_W-1] ^ det_neg;
      end
   end

   lrbd_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (numhi_ff),
      .num_lo (numlo_ff),
      .den    (den_ff),
      .done   (div_done),
      .result (div_result)
   );

   // ---------------------------------------------------------------------
   // Distance update. The quotient is truncated toward zero, then saturated
   // to 32 bits. A hit replaces the kept one only when its magnitude is
   // strictly smaller, so the first of equal distances stays.
   // ---------------------------------------------------------------------
   logic [COORD_W-1:0] t_val, t_mag, best_mag;

   always_comb begin
      if (neg_ff) begin
         if (div_result.sat || div_result.quot > {1'b0, 1'b1, {(QUOT_W-2){1'b0}}}) begin
            t_val = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            t_val = '0 - div_result.quot[COORD_W-1:0];
         end
      end else begin
         if (div_result.sat || div_result.quot > {2'b00, {(QUOT_W-2){1'b1}}}) begin
            t_val = {1'b0, {(COORD_W-1){1'b1}}};
         end else begin
            t_val = div_result.quot[COORD_W-1:0];
         end
      end
   end

   assign t_mag    = t_val[COORD_W-1] ? ('0 - t_val) : t_val;
   assign best_mag = best_distance_ff[COORD_W-1] ? ('0 - best_distance_ff) : best_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff        <= '0;
         prev_y_ff        <= '0;
         have_prev_ff     <= 1'b0;
         best_distance_ff <= '0;
         best_valid_ff    <= 1'b0;
      end else if (emit_load) begin
         prev_x_ff        <= '0;
         prev_y_ff        <= '0;
         have_prev_ff     <= 1'b0;
         best_distance_ff <= '0;
         best_valid_ff    <= 1'b0;
      end else begin
         if (req_valid && take_req) begin
            prev_x_ff    <= req_point_x;
            prev_y_ff    <= req_point_y;
            have_prev_ff <= 1'b1;
         end
         if (upd_en && (!best_valid_ff || t_mag < best_mag)) begin
            best_distance_ff <= t_val;
            best_valid_ff    <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register. It is loaded when empty or being drained. While an
   // earlier result still waits, the core holds in the emit state and takes
   // no new request.
   // ---------------------------------------------------------------------
   assign rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_load) begin
         rsp_found_ff    <= best_valid_ff;
         rsp_distance_ff <= best_valid_ff ? best_distance_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_lateral_distance = rsp_distance_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      !best_valid_ff |-> best_distance_ff == '0)
      else $error("kept distance is nonzero without a kept hit");

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_lateral_distance == '0)
      else $error("result without a hit carries a nonzero distance");

   a_div_only_with_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DWAIT) |-> have_prev_ff)
      else $error("division running without a previous vertex");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("divider finished right after its start");

endmodule
